// ===== hdl/ogmu_pkg.sv =====
// Package: sizes, command codes and interface structs of the Gaussian mixture update core.
package ogmu_pkg;

   localparam int NUM_GAUSS = 4;
   localparam int IW        = (NUM_GAUSS > 1) ? $clog2(NUM_GAUSS) : 1;
   localparam int SUM_W     = 17 + $clog2(NUM_GAUSS);
   localparam int NUM_W     = 34;
   localparam int DIV_STEPS = 17;
   localparam int SQRT_STEPS = 32;
   localparam int CNT_W     = 6;
   localparam int ENTRY_W   = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 31;

   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_GAUSS - 1);
   localparam logic [IW-1:0] PENULT_IDX = IW'((NUM_GAUSS > 1) ? NUM_GAUSS - 2 : 0);

   localparam logic [16:0] ONE_Q16 = 17'h10000;
   localparam logic [30:0] STD_MAX = 31'h7FFF_FFFF;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_RATE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_RATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STD_INIT    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_W_INIT      = 2'd3;

   // Datapath operations.
   localparam logic [4:0] OP_NONE  = 5'd0;
   localparam logic [4:0] OP_LOAD  = 5'd1;
   localparam logic [4:0] OP_START = 5'd2;
   localparam logic [4:0] OP_SCAN  = 5'd3;
   localparam logic [4:0] OP_MEAN  = 5'd4;
   localparam logic [4:0] OP_SQ    = 5'd5;
   localparam logic [4:0] OP_VAR   = 5'd6;
   localparam logic [4:0] OP_ROOT  = 5'd7;
   localparam logic [4:0] OP_WB    = 5'd8;
   localparam logic [4:0] OP_NLOAD = 5'd9;
   localparam logic [4:0] OP_NDIV  = 5'd10;
   localparam logic [4:0] OP_NDONE = 5'd11;
   localparam logic [4:0] OP_SLOAD = 5'd12;
   localparam logic [4:0] OP_SCMP  = 5'd13;
   localparam logic [4:0] OP_SSWAP = 5'd14;
   localparam logic [4:0] OP_REPL  = 5'd15;
   localparam logic [4:0] OP_EMIT  = 5'd16;

   typedef struct packed {
      logic [4:0]    op;
      logic [IW-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic matched;
      logic out_free;
   } status_type;

endpackage

// ===== hdl/ogmu_ctrl.sv =====
// Sequencer: start, or scan, update, normalize, sort and replace; then emit.
module ogmu_ctrl
   import ogmu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_start_req,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_START = 4'd1;
   localparam logic [3:0] ST_SCAN  = 4'd2;
   localparam logic [3:0] ST_MEAN  = 4'd3;
   localparam logic [3:0] ST_SQ    = 4'd4;
   localparam logic [3:0] ST_VAR   = 4'd5;
   localparam logic [3:0] ST_ROOT  = 4'd6;
   localparam logic [3:0] ST_WB    = 4'd7;
   localparam logic [3:0] ST_NLOAD = 4'd8;
   localparam logic [3:0] ST_NDIV  = 4'd9;
   localparam logic [3:0] ST_NDONE = 4'd10;
   localparam logic [3:0] ST_SLOAD = 4'd11;
   localparam logic [3:0] ST_SCMP  = 4'd12;
   localparam logic [3:0] ST_SSWAP = 4'd13;
   localparam logic [3:0] ST_REPL  = 4'd14;
   localparam logic [3:0] ST_EMIT  = 4'd15;

   logic [3:0]       state_ff, state_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      cmd.op    = OP_NONE;
      cmd.idx   = idx_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               idx_in   = '0;
               state_in = req_start_req ? ST_START : ST_SCAN;
            end
         end
         ST_START: begin
            cmd.op   = OP_START;
            idx_in   = '0;
            state_in = ST_EMIT;
         end
         ST_SCAN: begin
            cmd.op = OP_SCAN;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_MEAN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_MEAN: begin
            cmd.op   = OP_MEAN;
            idx_in   = '0;
            state_in = status.matched ? ST_SQ : ST_NLOAD;
         end
         ST_SQ: begin
            cmd.op   = OP_SQ;
            state_in = ST_VAR;
         end
         ST_VAR: begin
            cmd.op   = OP_VAR;
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.op = OP_ROOT;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            cmd.op   = OP_WB;
            idx_in   = '0;
            state_in = ST_NLOAD;
         end
         ST_NLOAD: begin
            cmd.op   = OP_NLOAD;
            cnt_in   = '0;
            state_in = ST_NDIV;
         end
         ST_NDIV: begin
            cmd.op = OP_NDIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_NDONE;
            end
         end
         ST_NDONE: begin
            cmd.op = OP_NDONE;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = (NUM_GAUSS > 1) ? ST_SLOAD : ST_REPL;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_NLOAD;
            end
         end
         ST_SLOAD: begin
            cmd.op   = OP_SLOAD;
            cnt_in   = CNT_W'(idx_ff) + 1'b1;
            state_in = ST_SCMP;
         end
         ST_SCMP: begin
            cmd.op  = OP_SCMP;
            cmd.idx = cnt_ff[IW-1:0];
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff[IW-1:0] == LAST_IDX) begin
               state_in = ST_SSWAP;
            end
         end
         ST_SSWAP: begin
            cmd.op = OP_SSWAP;
            if (idx_ff == PENULT_IDX) begin
               state_in = ST_REPL;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SLOAD;
            end
         end
         ST_REPL: begin
            cmd.op   = OP_REPL;
            idx_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.op = OP_EMIT;
            if (status.out_free) begin
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== hdl/ogmu_datapath.sv =====
// Datapath: mixture registers, blend multipliers, root and divider steps, sort and output.
module ogmu_datapath
   import ogmu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic signed [31:0]    req_sample,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ENTRY_W-1:0]    rsp_entry_index,
   output logic signed [31:0]    rsp_mean,
   output logic [30:0]           rsp_std_dev,
   output logic [16:0]           rsp_weight,
   output logic                  rsp_matched,
   output logic                  rsp_last
);

   function automatic logic [16:0] wblend(input logic [16:0] w, input logic [16:0] v,
                                          input logic [16:0] r);
      logic signed [17:0] diff;
      logic signed [35:0] prod;
      logic signed [35:0] sh;
      diff = $signed({1'b0, v}) - $signed({1'b0, w});
      prod = diff * $signed({1'b0, r});
      sh   = (prod + 36'sd32768) >>> 16;
      return w + sh[16:0];
   endfunction

   // floor(a * k / 2^16), split so the products stay narrow.
   function automatic logic [63:0] scale16(input logic [63:0] a, input logic [16:0] k);
      logic [64:0] hi;
      logic [32:0] lo;
      hi = a[63:16] * k;
      lo = a[15:0] * k;
      return hi[63:0] + 64'(lo[32:16]);
   endfunction

   logic [16:0] mean_rate_ff, weight_rate_ff, w_init_ff;
   logic [30:0] std_init_ff;

   logic signed [31:0] mean_ff [NUM_GAUSS];
   logic [30:0]        std_ff [NUM_GAUSS];
   logic [16:0]        weight_ff [NUM_GAUSS];

   logic signed [31:0] x_ff;
   logic               matched_ff;
   logic [IW-1:0]      match_idx_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic signed [31:0] nm_ff;
   logic [61:0]        sqs_ff;
   logic [63:0]        sqd_ff;
   logic [63:0]        rx_ff, res_ff, bit_ff;
   logic [SUM_W-1:0]   rem_ff;
   logic [DIV_STEPS-1:0] dnum_ff, quot_ff;
   logic [IW-1:0]      best_idx_ff;
   logic signed [31:0] best_m_ff;
   logic [30:0]        best_s_ff;
   logic [16:0]        best_w_ff;
   logic               rsp_valid_ff;

   logic [16:0] mr, wr, k_keep, w_init_c;
   logic [IW-1:0] rd_idx;
   logic signed [31:0] rd_m;
   logic [30:0] rd_s;
   logic [16:0] rd_w;
   logic out_free;

   assign mr       = (mean_rate_ff > ONE_Q16) ? ONE_Q16 : mean_rate_ff;
   assign wr       = (weight_rate_ff > ONE_Q16) ? ONE_Q16 : weight_rate_ff;
   assign w_init_c = (w_init_ff > ONE_Q16) ? ONE_Q16 : w_init_ff;
   assign k_keep   = ONE_Q16 - mr;

   assign rd_idx = (cmd.op == OP_MEAN || cmd.op == OP_SQ || cmd.op == OP_WB)
                   ? match_idx_ff : cmd.idx;
   assign rd_m = mean_ff[rd_idx];
   assign rd_s = std_ff[rd_idx];
   assign rd_w = weight_ff[rd_idx];

   // Match test and weight update of the scanned entry.
   logic signed [32:0] d_s;
   logic [32:0]        ad;
   logic               take;
   logic [16:0]        new_w;
   assign d_s   = {x_ff[31], x_ff} - {rd_m[31], rd_m};
   assign ad    = d_s[32] ? 33'(-d_s) : 33'(d_s);
   assign take  = !matched_ff && ({ad, 1'b0} <= ({1'b0, rd_s, 2'b00} + {3'b000, rd_s}));
   assign new_w = wblend(rd_w, take ? ONE_Q16 : 17'd0, wr);

   // Mean blend toward the sample.
   logic signed [50:0] pm;
   logic signed [50:0] pr;
   logic signed [33:0] nm;
   assign pm = d_s * $signed({1'b0, mr});
   assign pr = (pm + 51'sd32768) >>> 16;
   assign nm = {{2{rd_m[31]}}, rd_m} + pr[33:0];

   // Distance to the new mean; it always fits in 32 bits.
   logic signed [32:0] dn;
   logic [32:0]        adn;
   assign dn  = {x_ff[31], x_ff} - {nm_ff[31], nm_ff};
   assign adn = dn[32] ? 33'(-dn) : 33'(dn);

   logic [63:0] root_t;
   assign root_t = res_ff + bit_ff;

   logic [SUM_W:0]   div_t;
   logic [NUM_W-1:0] num;
   assign div_t = {rem_ff, dnum_ff[DIV_STEPS-1]};
   assign num   = {1'b0, rd_w, 16'd0} + NUM_W'(sum_ff >> 1);

   logic [47:0] lhs, rhs;
   assign lhs = best_w_ff * rd_s;
   assign rhs = rd_w * best_s_ff;

   assign out_free        = !rsp_valid_ff || rsp_ready;
   assign status.out_free = out_free;
   assign status.matched  = matched_ff;
   assign rsp_valid       = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_rate_ff   <= 17'd3277;
         weight_rate_ff <= 17'd328;
         std_init_ff    <= 31'd1966080;
         w_init_ff      <= 17'd3277;
         for (int i = 0; i < NUM_GAUSS; i++) begin
            mean_ff[i]   <= '0;
            std_ff[i]    <= '0;
            weight_ff[i] <= '0;
         end
         matched_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_MEAN_RATE:   mean_rate_ff   <= csr_wdata[16:0];
               CSR_WEIGHT_RATE: weight_rate_ff <= csr_wdata[16:0];
               CSR_STD_INIT:    std_init_ff    <= csr_wdata[30:0];
               CSR_W_INIT:      w_init_ff      <= csr_wdata[16:0];
               default: ;
            endcase
         end
         // A new result loads the output; otherwise an accepted one frees it.
         if (cmd.op == OP_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (cmd.op)
            OP_LOAD: begin
               x_ff       <= req_sample;
               matched_ff <= 1'b0;
               sum_ff     <= '0;
            end
            OP_START: begin
               for (int i = 0; i < NUM_GAUSS; i++) begin
                  mean_ff[i]   <= x_ff;
                  std_ff[i]    <= std_init_ff;
                  weight_ff[i] <= w_init_c;
               end
            end
            OP_SCAN: begin
               weight_ff[rd_idx] <= new_w;
               sum_ff            <= sum_ff + SUM_W'(new_w);
               if (take) begin
                  matched_ff   <= 1'b1;
                  match_idx_ff <= rd_idx;
               end
            end
            OP_MEAN: begin
               nm_ff <= nm[31:0];
            end
            OP_SQ: begin
               sqs_ff <= rd_s * rd_s;
               sqd_ff <= adn[31:0] * adn[31:0];
            end
            OP_VAR: begin
               rx_ff  <= scale16({2'b00, sqs_ff}, k_keep) + scale16(sqd_ff, mr);
               res_ff <= '0;
               bit_ff <= 64'h4000_0000_0000_0000;
            end
            OP_ROOT: begin
               if (rx_ff >= root_t) begin
                  rx_ff  <= rx_ff - root_t;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end
            OP_WB: begin
               mean_ff[rd_idx] <= nm_ff;
               std_ff[rd_idx]  <= (res_ff > 64'(STD_MAX)) ? STD_MAX : res_ff[30:0];
            end
            OP_NLOAD: begin
               rem_ff  <= SUM_W'(num >> DIV_STEPS);
               dnum_ff <= num[DIV_STEPS-1:0];
               quot_ff <= '0;
            end
            OP_NDIV: begin
               dnum_ff <= dnum_ff << 1;
               if (div_t >= {1'b0, sum_ff}) begin
                  rem_ff  <= SUM_W'(div_t - {1'b0, sum_ff});
                  quot_ff <= {quot_ff[DIV_STEPS-2:0], 1'b1};
               end else begin
                  rem_ff  <= div_t[SUM_W-1:0];
                  quot_ff <= {quot_ff[DIV_STEPS-2:0], 1'b0};
               end
            end
            OP_NDONE: begin
               weight_ff[rd_idx] <= (sum_ff == '0) ? 17'd0 : quot_ff[16:0];
            end
            OP_SLOAD: begin
               best_idx_ff <= rd_idx;
               best_m_ff   <= rd_m;
               best_s_ff   <= rd_s;
               best_w_ff   <= rd_w;
            end
            OP_SCMP: begin
               if (lhs < rhs) begin
                  best_idx_ff <= rd_idx;
                  best_m_ff   <= rd_m;
                  best_s_ff   <= rd_s;
                  best_w_ff   <= rd_w;
               end
            end
            OP_SSWAP: begin
               if (best_idx_ff != rd_idx) begin
                  mean_ff[best_idx_ff]   <= rd_m;
                  std_ff[best_idx_ff]    <= rd_s;
                  weight_ff[best_idx_ff] <= rd_w;
                  mean_ff[rd_idx]        <= best_m_ff;
                  std_ff[rd_idx]         <= best_s_ff;
                  weight_ff[rd_idx]      <= best_w_ff;
               end
            end
            OP_REPL: begin
               if (!matched_ff) begin
                  mean_ff[NUM_GAUSS-1]   <= x_ff;
                  std_ff[NUM_GAUSS-1]    <= std_init_ff;
                  weight_ff[NUM_GAUSS-1] <= wr;
               end
            end
            default: ;
         endcase
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT && out_free) begin
         rsp_entry_index <= ENTRY_W'(rd_idx);
         rsp_mean        <= rd_m;
         rsp_std_dev     <= rd_s;
         rsp_weight      <= rd_w;
         rsp_matched     <= matched_ff;
         rsp_last        <= (rd_idx == LAST_IDX);
      end
   end

endmodule

// ===== hdl/online_gaussian_mixture_update_core.sv =====
// Top level of the online Gaussian mixture update core.
// A start item goes from the start step straight to the emit of its results. Any other item
// scans every entry; on a match it then blends the mean and runs the 32-step root for the std,
// then normalizes each weight with the 17-step divider, sorts, and replaces the last entry when
// nothing matched. One item at a time: the next is taken once the last result is emitted.
// Reset (synchronous, active high) loads the register defaults and clears every entry to zero.

module online_gaussian_mixture_update_core
   import ogmu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [31:0]    req_sample,
   input  logic                  req_start_req,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ENTRY_W-1:0]    rsp_entry_index,
   output logic signed [31:0]    rsp_mean,
   output logic [30:0]           rsp_std_dev,
   output logic [16:0]           rsp_weight,
   output logic                  rsp_matched,
   output logic                  rsp_last,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // The controller owns all sequencing; the datapath only executes one command per cycle.
   cmd_type    cmd;
   status_type status;

   ogmu_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_start_req (req_start_req),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   // The datapath holds the mixture, the configuration registers and the output register,
   // so a finished result can wait on the output while the next item is taken.
   ogmu_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample      (req_sample),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_entry_index (rsp_entry_index),
      .rsp_mean        (rsp_mean),
      .rsp_std_dev     (rsp_std_dev),
      .rsp_weight      (rsp_weight),
      .rsp_matched     (rsp_matched),
      .rsp_last        (rsp_last)
   );

   // After an item is taken the block is not ready again in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again right after an accept");

   // While a result other than the last one waits, the emit sequence is still running.
   a_no_accept_mid_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input ready in the middle of an emit sequence");

   // Weights never exceed one.
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_weight <= ONE_Q16)
      else $error("emitted weight above one");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the online Gaussian mixture update core.
`timescale 1ns / 100ps

module testbench;
   import ogmu_pkg::*;

   // One emitted mixture entry as the block should present it.
   typedef struct {
      logic [ENTRY_W-1:0] entry_index;
      logic signed [31:0] mean;
      logic [30:0]        std_dev;
      logic [16:0]        weight;
      logic               matched;
      logic               last;
   } mix_entry_t;

   // A directed row. Start rows carry their expected entries typed in directly,
   // since a start simply copies the sample and the initial values everywhere.
   typedef struct {
      logic signed [31:0] sample;
      bit                 start;
      bit                 typed;
      logic [30:0]        typed_std;
      logic [16:0]        typed_weight;
   } directed_row_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic signed [31:0]    req_sample = '0;
   logic                  req_start_req = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [ENTRY_W-1:0]    rsp_entry_index;
   logic signed [31:0]    rsp_mean;
   logic [30:0]           rsp_std_dev;
   logic [16:0]           rsp_weight;
   logic                  rsp_matched;
   logic                  rsp_last;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Our own copy of the mixture and of the registers, as the block should hold them.
   logic signed [31:0] mix_mean [NUM_GAUSS];
   logic [30:0]        mix_std [NUM_GAUSS];
   logic [16:0]        mix_weight [NUM_GAUSS];
   logic [16:0]        reg_mean_rate;
   logic [16:0]        reg_weight_rate;
   logic [30:0]        reg_std_init;
   logic [16:0]        reg_w_init;

   mix_entry_t pending_entries[$];
   int         error_count = 0;
   int         stall_pct = 30;
   bit         hold_off_req = 1'b0;
   bit         feeding_done = 1'b0;

   online_gaussian_mixture_update_core dut (.*);

   always #5 clock = ~clock;

   // Clamp a Q1.16 register to one.
   function automatic logic [16:0] clamp_one(logic [16:0] v);
      return (v > ONE_Q16) ? ONE_Q16 : v;
   endfunction

   // Move m toward v at Q1.16 rate r, rounding half up (floor of the shifted sum).
   function automatic longint blend_q16(longint m, longint v, longint r);
      longint p;
      p = (v - m) * r + 64'sd32768;
      return m + (p >>> 16);
   endfunction

   // floor(a * k / 65536) for k up to one, split so that nothing overflows.
   function automatic bit [63:0] scale_q16(bit [63:0] a, bit [63:0] k);
      return (a >> 16) * k + (((a & 64'hFFFF) * k) >> 16);
   endfunction

   function automatic void reset_mixture();
      reg_mean_rate   = 17'd3277;
      reg_weight_rate = 17'd328;
      reg_std_init    = 31'd1966080;
      reg_w_init      = 17'd3277;
      for (int i = 0; i < NUM_GAUSS; i++) begin
         mix_mean[i]   = '0;
         mix_std[i]    = '0;
         mix_weight[i] = '0;
      end
   endfunction

   // Apply one sample to the mixture copy and queue the entries it should emit.
   function automatic void predict_update(logic signed [31:0] smp, bit st);
      longint     x, d, nm;
      bit [63:0]  ad, s, var_q, root, bitv, sum, lhs, rhs;
      bit [16:0]  mr, wr;
      bit         hit;
      int         best;
      logic signed [31:0] tm;
      logic [30:0] ts;
      logic [16:0] tw;
      mix_entry_t e;
      x   = longint'(smp);
      mr  = clamp_one(reg_mean_rate);
      wr  = clamp_one(reg_weight_rate);
      hit = 1'b0;
      if (st) begin
         for (int i = 0; i < NUM_GAUSS; i++) begin
            mix_mean[i]   = smp;
            mix_std[i]    = reg_std_init;
            mix_weight[i] = clamp_one(reg_w_init);
         end
      end else begin
         sum = 0;
         for (int i = 0; i < NUM_GAUSS; i++) begin
            d  = x - longint'(mix_mean[i]);
            ad = (d < 0) ? -d : d;
            if (!hit && 2 * ad <= 5 * 64'(mix_std[i])) begin
               // Matched entry: blend the mean, then refresh the variance.
               nm = blend_q16(mix_mean[i], x, mr);
               d  = x - nm;
               ad = (d < 0) ? -d : d;
               if (ad > 64'hFFFF_FFFF) ad = 64'hFFFF_FFFF;
               s = 64'(mix_std[i]);
               var_q = scale_q16(s * s, 64'(ONE_Q16 - mr)) + scale_q16(ad * ad, 64'(mr));
               // Floor integer square root, digit by digit.
               root = 0;
               bitv = 64'd1 << 62;
               while (bitv > var_q) bitv >>= 2;
               while (bitv != 0) begin
                  if (var_q >= root + bitv) begin
                     var_q = var_q - (root + bitv);
                     root  = (root >> 1) + bitv;
                  end else begin
                     root >>= 1;
                  end
                  bitv >>= 2;
               end
               mix_mean[i]   = nm[31:0];
               mix_std[i]    = (root > 64'(STD_MAX)) ? STD_MAX : root[30:0];
               mix_weight[i] = 17'(blend_q16(mix_weight[i], ONE_Q16, wr));
               hit = 1'b1;
            end else begin
               mix_weight[i] = 17'(blend_q16(mix_weight[i], 0, wr));
            end
            sum += 64'(mix_weight[i]);
         end
         for (int i = 0; i < NUM_GAUSS; i++) begin
            if (sum == 0) mix_weight[i] = '0;
            else mix_weight[i] = 17'((64'(mix_weight[i]) * 65536 + sum / 2) / sum);
         end
         // Selection sort on weight over std, compared by cross multiplication.
         for (int j = 0; j < NUM_GAUSS - 1; j++) begin
            best = j;
            for (int i = j + 1; i < NUM_GAUSS; i++) begin
               lhs = 64'(mix_weight[best]) * 64'(mix_std[i]);
               rhs = 64'(mix_weight[i]) * 64'(mix_std[best]);
               if (lhs < rhs) best = i;
            end
            if (best != j) begin
               tm = mix_mean[j];   mix_mean[j]   = mix_mean[best];   mix_mean[best]   = tm;
               ts = mix_std[j];    mix_std[j]    = mix_std[best];    mix_std[best]    = ts;
               tw = mix_weight[j]; mix_weight[j] = mix_weight[best]; mix_weight[best] = tw;
            end
         end
         // A sample that fits nowhere replaces the lowest ranked entry.
         if (!hit) begin
            mix_mean[NUM_GAUSS-1]   = smp;
            mix_std[NUM_GAUSS-1]    = reg_std_init;
            mix_weight[NUM_GAUSS-1] = wr;
         end
      end
      for (int i = 0; i < NUM_GAUSS; i++) begin
         e.entry_index = ENTRY_W'(i);
         e.mean        = mix_mean[i];
         e.std_dev     = mix_std[i];
         e.weight      = mix_weight[i];
         e.matched     = hit;
         e.last        = (i == NUM_GAUSS - 1);
         pending_entries.push_back(e);
      end
   endfunction

   // Offer one item and hold it until the block takes it. Called right after a rising
   // edge; the handshake is sampled at the falling edge, where everything is settled.
   task automatic offer_item(logic signed [31:0] smp, bit st);
      bit taken;
      req_valid     <= 1'b1;
      req_sample    <= smp;
      req_start_req <= st;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Burst shaping on the sender: after an item, sometimes drop valid for a while.
   int burst_left = 0;
   task automatic maybe_gap();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait until every expected entry has come back, then let the block settle
   // before touching any register.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_all_regs(logic [CSR_DATA_W-1:0] mrate, logic [CSR_DATA_W-1:0] wrate,
                                 logic [CSR_DATA_W-1:0] sinit, logic [CSR_DATA_W-1:0] winit);
      csr_we <= 1'b1; csr_index <= CSR_MEAN_RATE;   csr_wdata <= mrate; @(posedge clock);
      csr_index <= CSR_WEIGHT_RATE; csr_wdata <= wrate; @(posedge clock);
      csr_index <= CSR_STD_INIT;    csr_wdata <= sinit; @(posedge clock);
      csr_index <= CSR_W_INIT;      csr_wdata <= winit; @(posedge clock);
      csr_we <= 1'b0;
      reg_mean_rate   = mrate[16:0];
      reg_weight_rate = wrate[16:0];
      reg_std_init    = sinit[30:0];
      reg_w_init      = winit[16:0];
      @(posedge clock);
   endtask

   // One phase of random trajectories. Most samples land near an existing entry so that
   // matching, sorting and renormalization are exercised; the rest are noise or restarts.
   task automatic random_phase(int count);
      logic signed [31:0] smp;
      bit     st;
      int     traj_left, k, pick;
      longint s, off;
      traj_left = 0;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (traj_left == 0 || pick < 4) begin
            st = 1'b1;
            traj_left = $urandom_range(3, 30);
            smp = ($urandom_range(0, 1) != 0) ? $urandom : $signed(32'($urandom_range(0, 1 << 24)))
                  - (1 << 23);
         end else begin
            st = 1'b0;
            traj_left--;
            if (pick < 12) begin
               smp = $urandom;
            end else begin
               k   = $urandom_range(0, NUM_GAUSS - 1);
               s   = longint'(mix_std[k]);
               off = longint'($urandom) % (3 * s + 1) - (3 * s) / 2;
               smp = 32'(longint'(mix_mean[k]) + off);
            end
         end
         // Once per phase the receiver goes quiet while items keep coming.
         if (n == count / 2) hold_off_req = 1'b1;
         offer_item(smp, st);
         predict_update(smp, st);
         maybe_gap();
      end
   endtask

   // Receiver: stalls on its own random pattern, with calm stretches and a long hold-off in every phase.
   initial begin
      int mode_left, hold_left;
      bit calm;
      mode_left = 0;
      hold_left = 0;
      calm = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left = 400;
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(20, 200);
            calm = ($urandom_range(0, 3) == 0);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Compare every accepted entry with the oldest expectation, field by field.
   always @(negedge clock) begin
      mix_entry_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_entries.size() == 0) begin
            $error("unexpected entry: index %0d mean %0d", rsp_entry_index, rsp_mean);
            error_count++;
         end else begin
            want = pending_entries.pop_front();
            if (rsp_entry_index !== want.entry_index) begin
               $error("entry_index: expected %0d, got %0d", want.entry_index, rsp_entry_index);
               error_count++;
            end
            if (rsp_mean !== want.mean) begin
               $error("mean: expected %0d, got %0d", want.mean, rsp_mean);
               error_count++;
            end
            if (rsp_std_dev !== want.std_dev) begin
               $error("std_dev: expected %0d, got %0d", want.std_dev, rsp_std_dev);
               error_count++;
            end
            if (rsp_weight !== want.weight) begin
               $error("weight: expected %0d, got %0d", want.weight, rsp_weight);
               error_count++;
            end
            if (rsp_matched !== want.matched) begin
               $error("matched: expected %0d, got %0d", want.matched, rsp_matched);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // Directed rows: the reset mixture used before any start (zero std means only an exact
   // hit matches), the sample extremes, starts with typed results, far samples that replace
   // the last entry, and repeats that pile weight onto one entry.
   directed_row_t directed_rows[] = '{
      '{32'sd0,             1'b0, 1'b0, 31'd0,       17'd0},
      '{32'sd5,             1'b0, 1'b0, 31'd0,       17'd0},
      '{32'sh7FFF_FFFF,     1'b1, 1'b1, 31'd1966080, 17'd3277},
      '{32'sh7FFF_FFFF,     1'b0, 1'b0, 31'd0,       17'd0},
      '{32'sh7FF0_0000,     1'b0, 1'b0, 31'd0,       17'd0},
      '{-32'sh8000_0000,    1'b0, 1'b0, 31'd0,       17'd0},
      '{-32'sh8000_0000,    1'b1, 1'b1, 31'd1966080, 17'd3277},
      '{-32'sh8000_0000,    1'b0, 1'b0, 31'd0,       17'd0},
      '{32'sh7FFF_FFFF,     1'b0, 1'b0, 31'd0,       17'd0},
      '{32'sd6553600,       1'b1, 1'b1, 31'd1966080, 17'd3277},
      '{32'sd6553600,       1'b0, 1'b0, 31'd0,       17'd0},
      '{32'sd6553600,       1'b0, 1'b0, 31'd0,       17'd0},
      '{32'sd11468800,      1'b0, 1'b0, 31'd0,       17'd0},
      '{32'sd11468801,      1'b0, 1'b0, 31'd0,       17'd0},
      '{-32'sd6553600,      1'b0, 1'b0, 31'd0,       17'd0},
      '{32'sd7000000,       1'b0, 1'b0, 31'd0,       17'd0},
      '{32'sd0,             1'b1, 1'b1, 31'd1966080, 17'd3277},
      '{32'sd1,             1'b0, 1'b0, 31'd0,       17'd0}
   };

   initial begin
      mix_entry_t e;
      reset_mixture();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset register values.
      foreach (directed_rows[r]) begin
         offer_item(directed_rows[r].sample, directed_rows[r].start);
         if (directed_rows[r].typed) begin
            // Still advance our copy, but queue the hand-written entries instead.
            predict_update(directed_rows[r].sample, 1'b1);
            repeat (NUM_GAUSS) void'(pending_entries.pop_back());
            for (int i = 0; i < NUM_GAUSS; i++) begin
               e.entry_index = ENTRY_W'(i);
               e.mean        = directed_rows[r].sample;
               e.std_dev     = directed_rows[r].typed_std;
               e.weight      = directed_rows[r].typed_weight;
               e.matched     = 1'b0;
               e.last        = (i == NUM_GAUSS - 1);
               pending_entries.push_back(e);
            end
         end else begin
            predict_update(directed_rows[r].sample, 1'b0);
         end
         maybe_gap();
      end
      random_phase(60);

      // Lowest settings: rates of zero, the smallest nonzero std, no starting weight.
      drain_and_settle();
      write_all_regs(0, 0, 1, 0);
      stall_pct = 10;
      random_phase(60);

      // Rates and weight at exactly one, the largest std.
      drain_and_settle();
      write_all_regs(31'h10000, 31'h10000, 31'h7FFF_FFFF, 31'h10000);
      stall_pct = 50;
      random_phase(60);

      // Registers above one are clamped; upper write bits of the short registers are dropped.
      drain_and_settle();
      write_all_regs(31'h7FFF_FFFF, 31'h7FFE_FFFF, 31'h0001_0000, 31'h5555_FFFF);
      stall_pct = 30;
      random_phase(60);

      // Ordinary random settings.
      drain_and_settle();
      write_all_regs(CSR_DATA_W'($urandom_range(1, 20000)), CSR_DATA_W'($urandom_range(1, 8000)),
                     CSR_DATA_W'($urandom_range(1 << 16, 1 << 24)),
                     CSR_DATA_W'($urandom_range(0, 65536)));
      stall_pct = 20;
      random_phase(80);

      drain_and_settle();
      write_all_regs(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                     CSR_DATA_W'($urandom));
      random_phase(60);

      req_valid <= 1'b0;
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Roughly 400 items, with stalls, stay far below this.
   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
